// ----- hdl/vtp_pkg.sv -----
// Shared constants and types for the vertex transform with perspective divide.
`default_nettype none
package vtp_pkg;
    localparam int LANE_W   = 16;
    localparam int NUM_ROWS = 4;
    localparam int NUM_COLS = 4;
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 5;

    typedef logic [DATA_W-1:0] t_row;

    typedef enum logic [1:0] {
        ROW_ZERO  = 2'd0,
        ROW_ONE   = 2'd1,
        ROW_TWO   = 2'd2,
        ROW_THREE = 2'd3
    } t_reg_idx;

    localparam t_row ROW_ZERO_RST  = 64'h0000_0000_0000_0100;
    localparam t_row ROW_ONE_RST   = 64'h0000_0000_0100_0000;
    localparam t_row ROW_TWO_RST   = 64'h0000_0100_0000_0000;
    localparam t_row ROW_THREE_RST = 64'h0100_0000_0000_0000;
endpackage
`default_nettype wire

// ----- hdl/vertex_transform_perspective_top.sv -----
// Top level of the 4x4 vertex transform with pipelined perspective divide.
// A start beat runs through stages A to D, the divider and the final stage to o_done.
// Throughput: one beat per cycle while busy is low; one quotient bit per divider stage.
// The receiver cannot stall; busy is set in reset and clears on the first clock out of it.
// Reset is synchronous and active low; it clears every valid bit and loads
// the identity matrix into the four row registers.
`default_nettype none
module vertex_transform_perspective_top #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_in_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_in_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_in_z,
    output logic                               o_done,
    output logic signed [COORD_WIDTH-1:0]      o_out_x,
    output logic signed [COORD_WIDTH-1:0]      o_out_y,
    output logic signed [COORD_WIDTH-1:0]      o_out_z,
    output logic                               o_w_was_zero,
    output logic                               o_saturated,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vtp_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [vtp_pkg::DATA_W-1:0]    pwdata,
    output logic [vtp_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    localparam int CW  = COORD_WIDTH;
    localparam int LW  = vtp_pkg::LANE_W;
    localparam int PW  = CW + LW;
    localparam int SW  = ((CW > FRAC_BITS) ? CW : FRAC_BITS) + LW + 2;
    localparam int EW  = SW + FRAC_BITS + CW;
    localparam int LAT = CW + 5;
    localparam longint HI_L = (longint'(1) <<< (CW - 1)) - 1;
    localparam logic signed [SW-1:0] HI = SW'(HI_L);
    localparam logic signed [SW-1:0] LO = -HI - SW'(1);

    // Configuration registers.
    vtp_pkg::t_row r_row [0:vtp_pkg::NUM_ROWS-1];
    vtp_pkg::t_reg_idx w_idx;
    logic r_busy;

    assign w_idx  = vtp_pkg::t_reg_idx'(paddr[vtp_pkg::ADDR_W-1:3]);
    assign pready = 1'b1;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[vtp_pkg::ROW_ZERO]  <= vtp_pkg::ROW_ZERO_RST;
            r_row[vtp_pkg::ROW_ONE]   <= vtp_pkg::ROW_ONE_RST;
            r_row[vtp_pkg::ROW_TWO]   <= vtp_pkg::ROW_TWO_RST;
            r_row[vtp_pkg::ROW_THREE] <= vtp_pkg::ROW_THREE_RST;
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (psel && penable && pwrite) begin
                case (w_idx)
                    vtp_pkg::ROW_ZERO:  r_row[vtp_pkg::ROW_ZERO]  <= pwdata;
                    vtp_pkg::ROW_ONE:   r_row[vtp_pkg::ROW_ONE]   <= pwdata;
                    vtp_pkg::ROW_TWO:   r_row[vtp_pkg::ROW_TWO]   <= pwdata;
                    vtp_pkg::ROW_THREE: r_row[vtp_pkg::ROW_THREE] <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (w_idx)
            vtp_pkg::ROW_ZERO:  prdata = r_row[vtp_pkg::ROW_ZERO];
            vtp_pkg::ROW_ONE:   prdata = r_row[vtp_pkg::ROW_ONE];
            vtp_pkg::ROW_TWO:   prdata = r_row[vtp_pkg::ROW_TWO];
            vtp_pkg::ROW_THREE: prdata = r_row[vtp_pkg::ROW_THREE];
            default:            prdata = '0;
        endcase
    end

    function automatic logic [CW:0] sat_clamp(input logic signed [SW-1:0] v);
        logic [CW:0] res;
        if (v > HI) begin
            res = {1'b1, HI[CW-1:0]};
        end else if (v < LO) begin
            res = {1'b1, LO[CW-1:0]};
        end else begin
            res = {1'b0, v[CW-1:0]};
        end
        return res;
    endfunction

    // Stage A: products and translation terms.
    logic signed [CW-1:0] w_pt [0:2];
    logic signed [PW-1:0] r_prod [0:vtp_pkg::NUM_ROWS-1][0:2];
    logic signed [SW-1:0] r_trans [0:vtp_pkg::NUM_ROWS-1];
    logic r_va, r_vb, r_vc;

    assign w_pt[0] = i_in_x;
    assign w_pt[1] = i_in_y;
    assign w_pt[2] = i_in_z;

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < vtp_pkg::NUM_ROWS; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[r][c] <= PW'($signed(r_row[r][c*LW +: LW])) * PW'(w_pt[c]);
            end
            r_trans[r] <= SW'($signed(r_row[r][3*LW +: LW])) <<< FRAC_BITS;
        end
    end

    // Stage B: row sums.
    logic signed [SW-1:0] r_sum [0:vtp_pkg::NUM_ROWS-1];

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < vtp_pkg::NUM_ROWS; r++) begin
            r_sum[r] <= SW'(r_prod[r][0]) + SW'(r_prod[r][1]) + SW'(r_prod[r][2])
                      + r_trans[r];
        end
    end

    // Stage C: magnitudes, signs and the zero-w result.
    logic [SW-1:0]        r_num [0:2];
    logic [SW-1:0]        r_den;
    logic                 r_negc [0:2];
    logic                 r_wzc;
    logic [CW:0]          r_altc [0:2];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_num[k]  <= r_sum[k][SW-1] ? SW'(-r_sum[k]) : SW'(r_sum[k]);
            r_negc[k] <= r_sum[k][SW-1] ^ r_sum[vtp_pkg::ROW_THREE][SW-1];
            r_altc[k] <= sat_clamp(r_sum[k] >>> FRAC_BITS);
        end
        r_den <= r_sum[vtp_pkg::ROW_THREE][SW-1] ? SW'(-r_sum[vtp_pkg::ROW_THREE])
                                                 : SW'(r_sum[vtp_pkg::ROW_THREE]);
        r_wzc <= (r_sum[vtp_pkg::ROW_THREE] == '0);
    end

    // Stage D and the divider: each divider stage retires one quotient bit.
    logic [EW-1:0] r_rem [0:CW][0:2];
    logic [CW-1:0] r_quo [0:CW][0:2];
    logic          r_big [0:CW][0:2];
    logic          r_neg [0:CW][0:2];
    logic [CW:0]   r_alt [0:CW][0:2];
    logic [SW-1:0] r_dd  [0:CW];
    logic          r_wz  [0:CW];
    logic          r_vld [0:CW];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_rem[0][k] <= EW'(r_num[k]) << FRAC_BITS;
            r_big[0][k] <= (EW'(r_num[k]) << FRAC_BITS) >= (EW'(r_den) << CW);
            r_quo[0][k] <= '0;
            r_neg[0][k] <= r_negc[k];
            r_alt[0][k] <= r_altc[k];
        end
        r_dd[0] <= r_den;
        r_wz[0] <= r_wzc;
    end

    for (genvar j = 0; j < CW; j++) begin : g_div
        localparam int BI = CW - 1 - j;
        logic [EW-1:0] w_dsh;
        assign w_dsh = EW'(r_dd[j]) << BI;
        always_ff @(posedge i_clk) begin
            for (int k = 0; k < 3; k++) begin
                if (r_rem[j][k] >= w_dsh) begin
                    r_rem[j+1][k] <= r_rem[j][k] - w_dsh;
                end else begin
                    r_rem[j+1][k] <= r_rem[j][k];
                end
                r_quo[j+1][k] <= r_quo[j][k] | (CW'(r_rem[j][k] >= w_dsh) << BI);
                r_big[j+1][k] <= r_big[j][k];
                r_neg[j+1][k] <= r_neg[j][k];
                r_alt[j+1][k] <= r_alt[j][k];
            end
            r_dd[j+1] <= r_dd[j];
            r_wz[j+1] <= r_wz[j];
        end
    end

    // Final stage: sign, saturation and selection of the zero-w path.
    logic [CW-1:0] r_out [0:2];
    logic          r_sat, r_wzo, r_done;
    logic [CW-1:0] n_val [0:2];
    logic [2:0]    n_sat;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_wz[CW]) begin
                n_val[k] = r_alt[CW][k][CW-1:0];
                n_sat[k] = r_alt[CW][k][CW];
            end else if (r_neg[CW][k]) begin
                n_sat[k] = r_big[CW][k]
                         | (r_quo[CW][k][CW-1] & (|r_quo[CW][k][CW-2:0]));
                n_val[k] = n_sat[k] ? LO[CW-1:0] : CW'(-r_quo[CW][k]);
            end else begin
                n_sat[k] = r_big[CW][k] | r_quo[CW][k][CW-1];
                n_val[k] = n_sat[k] ? HI[CW-1:0] : r_quo[CW][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_out[k] <= n_val[k];
        end
        r_sat <= |n_sat;
        r_wzo <= r_wz[CW];
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va   <= 1'b0;
            r_vb   <= 1'b0;
            r_vc   <= 1'b0;
            r_done <= 1'b0;
            for (int j = 0; j <= CW; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            r_va     <= start && !r_busy;
            r_vb     <= r_va;
            r_vc     <= r_vb;
            r_vld[0] <= r_vc;
            for (int j = 0; j < CW; j++) begin
                r_vld[j+1] <= r_vld[j];
            end
            r_done <= r_vld[CW];
        end
    end

    assign o_done       = r_done;
    assign o_out_x      = r_out[0];
    assign o_out_y      = r_out[1];
    assign o_out_z      = r_out[2];
    assign o_w_was_zero = r_wzo;
    assign o_saturated  = r_sat;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("accepted beat did not complete after the pipeline latency");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching accepted beat");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated) |->
            (o_out_x == HI[CW-1:0] || o_out_x == LO[CW-1:0] ||
             o_out_y == HI[CW-1:0] || o_out_y == LO[CW-1:0] ||
             o_out_z == HI[CW-1:0] || o_out_z == LO[CW-1:0]))
        else $error("saturation flagged but no coordinate is at a range limit");
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the 4x4 vertex transform with perspective divide.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = 16;
    localparam int FB        = 8;
    localparam int LATENCY   = CW + 5;
    localparam int MAX_CYC   = 400000;
    localparam int RND_PHASE = 12;
    localparam int PER_PHASE = 55;

    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;
        logic                 wzero;
        logic                 sat;
    } t_vtx;

    typedef struct packed {
        int unsigned          phase;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 typed;
        t_vtx                 res;
    } t_dir;

    localparam int NDIR = 18;
    t_dir dir_tab [0:NDIR-1] = '{
        '{0,     0,      0,      0, 1'b1, '{     0,      0,      0, 1'b0, 1'b0}},
        '{0, 32767,  32767,  32767, 1'b1, '{ 32767,  32767,  32767, 1'b0, 1'b0}},
        '{0, -32768, -32768, -32768, 1'b1, '{-32768, -32768, -32768, 1'b0, 1'b0}},
        '{0,     1,     -1,    256, 1'b1, '{     1,     -1,    256, 1'b0, 1'b0}},
        '{0,  -256,    128,     -1, 1'b1, '{  -256,    128,     -1, 1'b0, 1'b0}},
        '{1,     0,      0,      0, 1'b1, '{     0,      0,      0, 1'b1, 1'b0}},
        '{1, 32767, -32768,      5, 1'b1, '{ 32767, -32768,      5, 1'b1, 1'b0}},
        '{1,    -1,      1,     -3, 1'b1, '{    -1,      1,     -3, 1'b1, 1'b0}},
        '{2, 32767,      0,      0, 1'b0, '0},
        '{2, -32768,   100,   -100, 1'b0, '0},
        '{2,   128,   -128,      7, 1'b0, '0},
        '{3,   256,   -256,      0, 1'b1, '{  -256,    256,      0, 1'b0, 1'b0}},
        '{3, -32768,     0,      1, 1'b1, '{ 32767,      0,     -1, 1'b0, 1'b1}},
        '{3, 32767,      1,     -1, 1'b1, '{-32767,     -1,      1, 1'b0, 1'b0}},
        '{4, 32767, -32768,      1, 1'b0, '0},
        '{4,    -1,     -1,     -1, 1'b0, '0},
        '{4,     0,      0,      0, 1'b0, '0},
        '{4,     1,      2,      3, 1'b0, '0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic signed [CW-1:0]          i_in_x = '0;
    logic signed [CW-1:0]          i_in_y = '0;
    logic signed [CW-1:0]          i_in_z = '0;
    logic                          o_done;
    logic signed [CW-1:0]          o_out_x;
    logic signed [CW-1:0]          o_out_y;
    logic signed [CW-1:0]          o_out_z;
    logic                          o_w_was_zero;
    logic                          o_saturated;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [vtp_pkg::ADDR_W-1:0]    paddr = '0;
    logic [vtp_pkg::DATA_W-1:0]    pwdata = '0;
    logic [vtp_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    vtp_pkg::t_row matrix [vtp_pkg::NUM_ROWS];
    t_vtx          pending_vertices [$];
    int unsigned   errors = 0;
    int unsigned   beats_in = 0;
    int unsigned   beats_out = 0;
    int unsigned   wzero_seen = 0;
    int unsigned   sat_seen = 0;
    int unsigned   cycles = 0;
    int unsigned   gap_pct = 0;

    vertex_transform_perspective_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint coef(vtp_pkg::t_row row, int col);
        return longint'($signed(row[col*vtp_pkg::LANE_W +: vtp_pkg::LANE_W]));
    endfunction

    function automatic longint div_q(longint num, longint den);
        bit                neg;
        longint unsigned   n, d, q, r, frac;
        neg  = (num < 0) != (den < 0);
        n    = (num < 0) ? -num : num;
        d    = (den < 0) ? -den : den;
        q    = n / d;
        r    = n % d;
        frac = 0;
        for (int i = 0; i < FB; i++) begin
            r    = r << 1;
            frac = frac << 1;
            if (r >= d) begin
                r    = r - d;
                frac = frac | 1;
            end
        end
        if (q > 64'h100_0000_0000) q = 64'h100_0000_0000;
        n = (q << FB) | frac;
        return neg ? -longint'(n) : longint'(n);
    endfunction

    function automatic t_vtx project_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                            logic signed [CW-1:0] z);
        longint sums [vtp_pkg::NUM_ROWS];
        longint v;
        t_vtx   res;
        res = '0;
        for (int r = 0; r < vtp_pkg::NUM_ROWS; r++) begin
            sums[r] = coef(matrix[r], 0) * longint'(x) + coef(matrix[r], 1) * longint'(y)
                    + coef(matrix[r], 2) * longint'(z) + coef(matrix[r], 3) * (64'sd1 << FB);
        end
        res.wzero = (sums[vtp_pkg::ROW_THREE] == 0);
        for (int k = 0; k < 3; k++) begin
            v = res.wzero ? (sums[k] >>> FB) : div_q(sums[k], sums[vtp_pkg::ROW_THREE]);
            if (v > 32767) begin
                v = 32767;
                res.sat = 1'b1;
            end else if (v < -32768) begin
                v = -32768;
                res.sat = 1'b1;
            end
            case (k)
                0: res.px = v[CW-1:0];
                1: res.py = v[CW-1:0];
                default: res.pz = v[CW-1:0];
            endcase
        end
        return res;
    endfunction

    task automatic write_row(vtp_pkg::t_reg_idx idx, vtp_pkg::t_row value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= vtp_pkg::ADDR_W'(int'(idx) * 8);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        matrix[idx] = value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value) begin
            $error("row %0d readback: expected %h, got %h", int'(idx), value, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_matrix(vtp_pkg::t_row m0, vtp_pkg::t_row m1, vtp_pkg::t_row m2,
                               vtp_pkg::t_row m3);
        write_row(vtp_pkg::ROW_ZERO, m0);
        write_row(vtp_pkg::ROW_ONE, m1);
        write_row(vtp_pkg::ROW_TWO, m2);
        write_row(vtp_pkg::ROW_THREE, m3);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                               logic signed [CW-1:0] z, logic typed, t_vtx res);
        int gap;
        start  <= 1'b1;
        i_in_x <= x;
        i_in_y <= y;
        i_in_z <= z;
        do @(posedge i_clk); while (busy);
        pending_vertices.push_back(typed ? res : project_vertex(x, y, z));
        beats_in++;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < gap_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [vtp_pkg::LANE_W-1:0] rand_lane();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2, 3, 4: return vtp_pkg::LANE_W'(int'($urandom_range(1200)) - 600);
            5, 6:          return vtp_pkg::LANE_W'($urandom);
            7:             return '0;
            8:             return 16'h0100;
            default: begin
                case ($urandom_range(2))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        if ($urandom_range(9) < 7) return CW'($urandom);
        return CW'(int'($urandom_range(2048)) - 1024);
    endfunction

    always @(posedge i_clk) begin
        t_vtx want;
        if (i_rst_n && o_done) begin
            beats_out++;
            if (pending_vertices.size() == 0) begin
                $error("result beat with no expectation pending");
                errors++;
            end else begin
                want = pending_vertices.pop_front();
                if (o_w_was_zero) wzero_seen++;
                if (o_saturated) sat_seen++;
                if (o_out_x !== want.px) begin
                    $error("out_x: expected %0d, got %0d", want.px, o_out_x);
                    errors++;
                end
                if (o_out_y !== want.py) begin
                    $error("out_y: expected %0d, got %0d", want.py, o_out_y);
                    errors++;
                end
                if (o_out_z !== want.pz) begin
                    $error("out_z: expected %0d, got %0d", want.pz, o_out_z);
                    errors++;
                end
                if (o_w_was_zero !== want.wzero) begin
                    $error("w_was_zero: expected %0b, got %0b", want.wzero, o_w_was_zero);
                    errors++;
                end
                if (o_saturated !== want.sat) begin
                    $error("saturated: expected %0b, got %0b", want.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("[vertex_transform_perspective_top] ERROR");
            $finish;
        end
    end

    initial begin
        vtp_pkg::t_row rows [vtp_pkg::NUM_ROWS];
        int unsigned cur_phase;
        matrix[vtp_pkg::ROW_ZERO]  = vtp_pkg::ROW_ZERO_RST;
        matrix[vtp_pkg::ROW_ONE]   = vtp_pkg::ROW_ONE_RST;
        matrix[vtp_pkg::ROW_TWO]   = vtp_pkg::ROW_TWO_RST;
        matrix[vtp_pkg::ROW_THREE] = vtp_pkg::ROW_THREE_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_phase = 0;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].phase != cur_phase) begin
                drain();
                cur_phase = dir_tab[i].phase;
                case (cur_phase)
                    1: load_matrix(vtp_pkg::ROW_ZERO_RST, vtp_pkg::ROW_ONE_RST,
                                   vtp_pkg::ROW_TWO_RST, '0);
                    2: load_matrix(64'h0100_0000_0000_0200, vtp_pkg::ROW_ONE_RST,
                                   vtp_pkg::ROW_TWO_RST, vtp_pkg::ROW_THREE_RST);
                    3: load_matrix(vtp_pkg::ROW_ZERO_RST, vtp_pkg::ROW_ONE_RST,
                                   vtp_pkg::ROW_TWO_RST, 64'hFF00_0000_0000_0000);
                    default: load_matrix('1, {4{16'h7FFF}}, {4{16'h8000}},
                                         64'h0000_0000_0000_0001);
                endcase
            end
            gap_pct = (i % 3 == 0) ? 50 : 0;
            send_vertex(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                        dir_tab[i].typed, dir_tab[i].res);
        end

        for (int ph = 0; ph < RND_PHASE; ph++) begin
            drain();
            for (int r = 0; r < vtp_pkg::NUM_ROWS; r++) begin
                for (int c = 0; c < vtp_pkg::NUM_COLS; c++) begin
                    rows[r][c*vtp_pkg::LANE_W +: vtp_pkg::LANE_W] = rand_lane();
                end
            end
            if (ph % 3 == 2) rows[vtp_pkg::ROW_THREE] = '0;
            load_matrix(rows[vtp_pkg::ROW_ZERO], rows[vtp_pkg::ROW_ONE],
                        rows[vtp_pkg::ROW_TWO], rows[vtp_pkg::ROW_THREE]);
            case (ph % 4)
                0:       gap_pct = 0;
                1:       gap_pct = 86;
                2:       gap_pct = 20;
                default: gap_pct = 36;
            endcase
            for (int n = 0; n < PER_PHASE; n++) begin
                send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
            end
        end
        drain();

        $display("Sent %0d vertex beats over %0d matrix settings; %0d results checked.",
                 beats_in, RND_PHASE + 5, beats_out);
        $display("Results with zero w: %0d; saturated results: %0d.", wzero_seen, sat_seen);
        if (errors == 0) begin
            $display("[vertex_transform_perspective_top] OK");
        end else begin
            $display("[vertex_transform_perspective_top] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/vtp_pkg.sv
hdl/vertex_transform_perspective_top.sv
dv/tb.sv
